>>> sv/stdel_pkg.sv
// ----------------------------------------------------------------------------
// stdel_pkg: shared types and codes for the sorted table
// Status codes, operation codes, controller states and the control
// group that the controller hands to every cell of the row.
// ----------------------------------------------------------------------------
package stdel_pkg;

    // Operation carried in the input word's tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Result status
    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_DELETED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Controller states
    typedef enum logic {
        S_IDLE   = 1'b0,
        S_COMMIT = 1'b1
    } state_t;

    // Control group broadcast to every cell
    typedef struct packed {
        logic capture;   // latch compare flags against the incoming key
        logic insert;    // shift right and drop the key in at the boundary
        logic remove;    // shift left from the boundary onward
    } cell_ctrl_t;

endpackage

>>> sv/stdel_cell.sv
// ----------------------------------------------------------------------------
// stdel_cell: one entry of the sorted table
// Holds one value, compares it against the key of a new word, and on
// commit keeps its value, takes the key, or takes a neighbor's value.
// ----------------------------------------------------------------------------
module stdel_cell
    import stdel_pkg::*;
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic               occupied,   // entry index below the count
    input  logic signed [31:0] key_in,     // key of the word being accepted
    input  logic signed [31:0] key_held,   // key of the word being committed
    input  logic signed [31:0] left_val,
    input  logic               left_lt,    // left neighbor holds a smaller value
    input  logic signed [31:0] right_val,
    output logic signed [31:0] val,
    output logic               lt,
    output logic               bound,      // first entry not smaller than the key
    output logic               hit         // boundary entry equal to the key
);

    logic signed [31:0] val_reg;
    logic signed [31:0] val_next;
    logic               lt_reg;
    logic               lt_next;
    logic               eq_reg;
    logic               eq_next;

    // Compare against the incoming key, hold otherwise
    always_comb
    begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (ctrl.capture)
        begin
            lt_next = occupied && (val_reg < key_in);
            eq_next = occupied && (val_reg == key_in);
        end
    end

    // Shift the row around the boundary
    always_comb
    begin
        val_next = val_reg;
        if (ctrl.insert && !lt_reg)
        begin
            val_next = left_lt ? key_held : left_val;
        end
        else if (ctrl.remove && !lt_reg)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        lt_reg  <= lt_next;
        eq_reg  <= eq_next;
    end

    assign val   = val_reg;
    assign lt    = lt_reg;
    assign bound = !lt_reg && left_lt;
    assign hit   = bound && eq_reg;

endmodule

>>> sv/sorted_table_insert_delete_core.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_delete_core: sorted table with insert and delete
// A row of compare-and-shift cells holding signed values in ascending order.
// ----------------------------------------------------------------------------
// When a word is accepted every cell compares its entry with the key at once;
// once the output register is free, the row shifts by one place around the
// first entry not smaller than the key (not for an insert into a full table
// or a delete with no equal entry) and the result word is written to the
// output register. A new word is not taken until the held one has committed,
// and the commit waits while an earlier result is still untaken.
// Entries above the count are never read, so there is no clearing pass after
// reset. Position and count are reported in 6 and 7 bits.
module sorted_table_insert_delete_core
    import stdel_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value
    input  logic [0:0]  s_tuser,    // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [5:0] position, [12:6] entry_count, [15:13] zero
    output logic [1:0]  m_tuser     // [1:0] status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = $clog2(CAPACITY);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic signed [31:0] key_reg;
    logic               op_reg;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    logic [15:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    cell_ctrl_t         ctrl;
    logic               accept;
    logic               commit;
    logic               full;
    logic               found;
    status_t            status;
    logic [POS_W-1:0]   pos;
    logic [POS_W+5:0]   pos_wide;
    logic [CNT_W+6:0]   cnt_wide;

    logic signed [31:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0] occ;
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_bound;
    logic [CAPACITY-1:0] cell_hit;

    assign accept = s_tvalid && s_tready;
    assign commit = (state_reg == S_COMMIT) && (!m_tvalid_reg || m_tready);
    assign full   = (count_reg >= CNT_W'(CAPACITY));
    assign found  = |cell_hit;

    // Controller: accept in idle, commit once the output register is free
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Decide the outcome of the held word
    always_comb
    begin
        ctrl.capture = accept;
        ctrl.insert  = 1'b0;
        ctrl.remove  = 1'b0;
        count_next   = count_reg;
        if (op_reg == OP_INSERT)
        begin
            status = full ? ST_FULL : ST_INSERTED;
            if (commit && !full)
            begin
                ctrl.insert = 1'b1;
                count_next  = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            status = found ? ST_DELETED : ST_NOT_FOUND;
            if (commit && found)
            begin
                ctrl.remove = 1'b1;
                count_next  = count_reg - CNT_W'(1);
            end
        end
    end

    // Encode the boundary cell into an index
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_bound[i])
            begin
                pos = pos | POS_W'(i);
            end
        end
    end

    assign pos_wide = {6'd0, pos};
    assign cnt_wide = {7'd0, count_next};

    // Output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (commit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold the word's payload and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= s_tdata;
            op_reg  <= s_tuser[0];
        end
        if (commit)
        begin
            m_tuser_reg <= status;
            m_tdata_reg <= {3'd0, cnt_wide[6:0],
                            ((status == ST_INSERTED) || (status == ST_DELETED))
                                ? pos_wide[5:0] : 6'd0};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [31:0] left_v;
        logic               left_l;
        logic signed [31:0] right_v;

        assign occ[i] = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign left_v = key_reg;
            assign left_l = 1'b1;
        end
        else
        begin : g_mid
            assign left_v = cell_val[i-1];
            assign left_l = cell_lt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_v = cell_val[i];
        end
        else
        begin : g_inner
            assign right_v = cell_val[i+1];
        end

        stdel_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occupied  (occ[i]),
            .key_in    (s_tdata),
            .key_held  (key_reg),
            .left_val  (left_v),
            .left_lt   (left_l),
            .right_val (right_v),
            .val       (cell_val[i]),
            .lt        (cell_lt[i]),
            .bound     (cell_bound[i]),
            .hit       (cell_hit[i])
        );
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> m_tvalid)
        else $error("committed word did not reach the output");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.insert |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not advance the count");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("word accepted while another is pending");

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: stream-level check of the sorted table core
// Sends insert and delete words and predicts each result word from a shadow
// copy of the table. Accepted results are compared field by field with the
// oldest prediction. Both sides idle at random, the output side stalls once
// for a long stretch, and the sender pauses between phases until the table
// engine has drained.
// ----------------------------------------------------------------------------
module tb
    import stdel_pkg::*;
();

    localparam int TABLE_DEPTH = 64;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 500;
    localparam int DRAIN_WAIT  = 20;

    typedef struct {
        logic               op;
        logic signed [31:0] value;
    } table_cmd_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  position;
        logic [6:0]  entry_count;
    } table_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    // Stimulus and prediction stores
    table_cmd_t         cmd_queue[$];
    table_result_t      expected_results[$];
    logic signed [31:0] table_shadow[TABLE_DEPTH];
    int                 held_count = 0;
    logic signed [31:0] issued_values[$];   // contents as seen by the generator

    bit in_taken = 1'b0;
    bit no_idle = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int accepted_inputs = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    sorted_table_insert_delete_core #(.CAPACITY(TABLE_DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Apply one word to the shadow table and return the result it causes
    function automatic table_result_t apply_table_op(logic op, logic signed [31:0] v);
        table_result_t r;
        int            pos;
        pos = 0;
        while (pos < held_count && table_shadow[pos] < v)
            pos++;
        r.position = '0;
        if (op == OP_INSERT)
        begin
            if (held_count >= TABLE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                for (int i = held_count; i > pos; i--)
                    table_shadow[i] = table_shadow[i - 1];
                table_shadow[pos] = v;
                held_count++;
                r.status = ST_INSERTED;
                r.position = pos[5:0];
            end
        end
        else
        begin
            if (pos >= held_count || table_shadow[pos] != v)
                r.status = ST_NOT_FOUND;
            else
            begin
                for (int i = pos; i + 1 < held_count; i++)
                    table_shadow[i] = table_shadow[i + 1];
                held_count--;
                r.status = ST_DELETED;
                r.position = pos[5:0];
            end
        end
        r.entry_count = held_count[6:0];
        return r;
    endfunction

    // Queue one word and track what the table will hold once it is taken
    function automatic void queue_cmd(logic op, logic signed [31:0] v);
        table_cmd_t c;
        c.op = op;
        c.value = v;
        cmd_queue.push_back(c);
        if (op == OP_INSERT)
        begin
            if (issued_values.size() < TABLE_DEPTH)
                issued_values.push_back(v);
        end
        else
        begin
            for (int i = 0; i < issued_values.size(); i++)
            begin
                if (issued_values[i] == v)
                begin
                    issued_values.delete(i);
                    break;
                end
            end
        end
    endfunction

    // Pick a value: half from small ranges so duplicates occur, plus full-range and edges
    function automatic logic signed [31:0] pick_value();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 4)
            return $urandom;
        else if (mode < 7)
            return $signed($urandom_range(0, 16)) - 8;
        else if (mode == 7)
        begin
            case ($urandom_range(0, 5))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh8000_0001;
                3: return 32'sh7fff_fffe;
                4: return 0;
                default: return -1;
            endcase
        end
        else
            return $signed($urandom_range(0, 2000)) - 1000;
    endfunction

    // Random words; deletes mostly target a value that is held
    task automatic queue_random(int count, int insert_pct);
        logic               op;
        logic signed [31:0] v;
        for (int n = 0; n < count; n++)
        begin
            op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
            if (op == OP_DELETE && issued_values.size() > 0 && $urandom_range(0, 99) < 85)
                v = issued_values[$urandom_range(0, issued_values.size() - 1)];
            else
                v = pick_value();
            queue_cmd(op, v);
        end
    endtask

    // Hold the sender until every queued word is taken and every result is back
    task automatic drain_all();
        while (cmd_queue.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
    endtask

    // Sender: advance on acceptance, idle at random
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (cmd_queue.size() > 0 && (no_idle || $urandom_range(0, 99) >= 28))
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= cmd_queue[0].op;
                s_tdata  <= cmd_queue[0].value;
                void'(cmd_queue.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: one long hold-off, otherwise random stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && accepted_inputs >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= no_idle || ($urandom_range(0, 99) >= 28);
        end
    end

    // Monitor: check result words, predict accepted input words, watch for stalls
    always @(posedge clk)
    begin
        table_result_t got;
        table_result_t want;
        if (rst_n)
        begin
            in_taken = s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got.status = status_t'(m_tuser);
                got.position = m_tdata[5:0];
                got.entry_count = m_tdata[12:6];
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d position %0d count %0d",
                                 got.status, got.position, got.entry_count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: status %0d/%0d position %0d/%0d count %0d/%0d",
                                     want.status, got.status, want.position, got.position,
                                     want.entry_count, got.entry_count);
                    end
                end
            end
            if (in_taken)
            begin
                expected_results.push_back(apply_table_op(s_tuser[0], $signed(s_tdata)));
                accepted_inputs++;
            end
            if (in_taken || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("tb failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty delete, extremes, duplicates, misses, hits
        queue_cmd(OP_DELETE, 0);
        queue_cmd(OP_INSERT, 0);
        queue_cmd(OP_INSERT, 32'sh7fff_ffff);
        queue_cmd(OP_INSERT, 32'sh8000_0000);
        queue_cmd(OP_INSERT, -1);
        queue_cmd(OP_INSERT, 1);
        queue_cmd(OP_INSERT, 0);
        queue_cmd(OP_INSERT, 5);
        queue_cmd(OP_INSERT, 5);
        queue_cmd(OP_INSERT, 32'sh8000_0000);
        queue_cmd(OP_DELETE, 5);
        queue_cmd(OP_DELETE, 7);
        queue_cmd(OP_DELETE, 32'sh8000_0000);
        queue_cmd(OP_DELETE, 32'sh7fff_ffff);
        queue_cmd(OP_DELETE, 32'sh7fff_ffff);
        queue_cmd(OP_DELETE, 0);
        queue_cmd(OP_DELETE, 0);
        queue_cmd(OP_DELETE, 0);
        queue_cmd(OP_INSERT, 32'sh5555_5555);
        queue_cmd(OP_INSERT, 32'shaaaa_aaaa);
        queue_cmd(OP_DELETE, 32'sh5555_5554);
        drain_all();

        // Balanced mix
        queue_random(400, 55);
        drain_all();

        // Fill past capacity with no idling on either side
        no_idle = 1'b1;
        queue_random(400, 85);
        drain_all();
        no_idle = 1'b0;

        // Empty the table and keep deleting past empty
        queue_random(350, 15);
        drain_all();

        // Balanced mix again
        queue_random(300, 50);
        drain_all();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_results.size() > 0)
        begin
            mismatches++;
            $display("%0d results never arrived", expected_results.size());
        end
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

>>> sim.f
sv/stdel_pkg.sv
sv/stdel_cell.sv
sv/sorted_table_insert_delete_core.sv
sim/tb.sv
